// ===== hw/rtl/swmc_pkg.sv =====
package swmc_pkg;
  localparam int unsigned MaxItemsDefault = 1024;
  localparam int unsigned PosW   = 10;
  localparam int unsigned CodeW  = 10;
  localparam int unsigned CountW = 11;
  localparam int unsigned CodeSpan = 1024;
  localparam int unsigned TreeDepth = 2 * CodeSpan;
  localparam int unsigned NodeW = 11;

  localparam logic       ActLoad  = 1'b0;
  localparam logic       ActQuery = 1'b1;
  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StBadRange = 2'd1;
  localparam logic [1:0] StBusy   = 2'd2;

  typedef struct packed {
    logic              action;
    logic [PosW-1:0]   position;
    logic [CodeW-1:0]  code;
    logic [PosW-1:0]   query_left;
    logic [PosW-1:0]   query_right;
  } in_item_t;

  typedef struct packed {
    logic              majority;
    logic [CountW-1:0] top_count;
    logic [1:0]        status;
  } out_item_t;
endpackage

// ===== hw/rtl/swmc_if.sv =====
interface swmc_in_if;
  import swmc_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface swmc_out_if;
  import swmc_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// ===== hw/rtl/swmc_ram.sv =====
module swmc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/sliding_window_majority_check_core.sv =====
// Channel | Direction | Handshake        | Payload
// in_ch   | sink      | valid/ready      | action, position, code, query_left, query_right
// out_ch  | source    | valid/ready      | majority, top_count, status
//
// One item at a time. A load or a rejected item goes from idle straight to the
// output state. A query walks the window to its new range move by move; each
// move is a code read, a count read/modify/write with the leaf write, and ten
// max-tree ancestor updates, each a sibling read and then a parent write.
// After reset a clearing pass zeroes counts and all 2048 tree nodes; no item
// is accepted during it. A stalled result holds the block; it does not drop.
module sliding_window_majority_check_core #(
  parameter int unsigned MaxItems = swmc_pkg::MaxItemsDefault
) (
  input logic clk,
  input logic rst_n,
  swmc_in_if.sink    in_ch,
  swmc_out_if.source out_ch
);
  import swmc_pkg::*;

  localparam int unsigned TreeAw = $clog2(TreeDepth);
  localparam int unsigned CntAw  = $clog2(CodeSpan);
  localparam logic [PosW-1:0] PosLimit =
      (MaxItems >= 1024) ? PosW'(1023) : PosW'(MaxItems - 1);

  // Sequencer states.
  localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_PLAN = 4'd2,
                         S_CODE = 4'd3, S_CNT = 4'd4, S_CNTW = 4'd5,
                         S_TRD = 4'd6, S_TWR = 4'd7, S_TOP = 4'd8,
                         S_TOPW = 4'd9, S_OUT = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic [TreeAw:0] clr_r, clr_nxt;
  logic [PosW-1:0] wl_r, wl_nxt, wr_r, wr_nxt, ql_r, ql_nxt, qr_r, qr_nxt;
  logic [PosW-1:0] fp_r, fp_nxt;
  logic            empty_r, empty_nxt, first_r, first_nxt;
  logic            inc_r, inc_nxt;
  logic [PosW-1:0] pos_r, pos_nxt;
  logic [CodeW-1:0] code_r, code_nxt;
  logic [TreeAw-1:0] node_r, node_nxt;
  logic [NodeW-1:0] val_r, val_nxt;
  out_item_t       res_r, res_nxt;
  logic            ovalid_r, ovalid_nxt;

  // Memory ports.
  logic               cs_we;
  logic [PosW-1:0]    cs_waddr, cs_raddr;
  logic [CodeW-1:0]   cs_wdata, cs_rdata;
  logic               cc_we;
  logic [CntAw-1:0]   cc_waddr, cc_raddr;
  logic [CountW-1:0]  cc_wdata, cc_rdata;
  logic               mt_we;
  logic [TreeAw-1:0]  mt_waddr, mt_raddr;
  logic [NodeW-1:0]   mt_wdata, mt_rdata;

  swmc_ram #(.Width(CodeW), .Depth(CodeSpan)) u_store (
    .clk, .we(cs_we), .waddr(cs_waddr), .wdata(cs_wdata),
    .raddr(cs_raddr), .rdata(cs_rdata));
  swmc_ram #(.Width(CountW), .Depth(CodeSpan)) u_counts (
    .clk, .we(cc_we), .waddr(cc_waddr), .wdata(cc_wdata),
    .raddr(cc_raddr), .rdata(cc_rdata));
  swmc_ram #(.Width(NodeW), .Depth(TreeDepth)) u_tree (
    .clk, .we(mt_we), .waddr(mt_waddr), .wdata(mt_wdata),
    .raddr(mt_raddr), .rdata(mt_rdata));

  function automatic logic [PosW-1:0] clamp(input logic [PosW-1:0] p);
    return (p > PosLimit) ? PosLimit : p;
  endfunction

  logic [PosW-1:0] in_l, in_r;
  logic [PosW:0]   len;
  logic [NodeW-1:0] mx;
  assign in_l = clamp(in_ch.item.query_left);
  assign in_r = clamp(in_ch.item.query_right);
  assign len  = {1'b0, qr_r} - {1'b0, ql_r} + (PosW+1)'(1);
  assign mx   = (mt_rdata > val_r) ? mt_rdata : val_r;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = ovalid_r;
  assign out_ch.item  = res_r;

  always_comb begin
    state_nxt = state_r; clr_nxt = clr_r;
    wl_nxt = wl_r; wr_nxt = wr_r; ql_nxt = ql_r; qr_nxt = qr_r;
    fp_nxt = fp_r; empty_nxt = empty_r; first_nxt = first_r; inc_nxt = inc_r;
    pos_nxt = pos_r; code_nxt = code_r; node_nxt = node_r; val_nxt = val_r;
    res_nxt = res_r; ovalid_nxt = ovalid_r;
    cs_we = 1'b0; cs_waddr = clamp(in_ch.item.position);
    cs_wdata = in_ch.item.code; cs_raddr = pos_r;
    cc_we = 1'b0; cc_waddr = code_r; cc_wdata = '0; cc_raddr = code_r;
    mt_we = 1'b0; mt_waddr = node_r; mt_wdata = val_r; mt_raddr = node_r ^ TreeAw'(1);
    case (state_r)
      S_CLEAR: begin
        mt_we = 1'b1; mt_waddr = clr_r[TreeAw-1:0]; mt_wdata = '0;
        cc_we = 1'b1; cc_waddr = clr_r[CntAw-1:0];
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (TreeAw+1)'(TreeDepth - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          res_nxt = '{majority: 1'b0, top_count: '0, status: StOk};
          if (in_ch.item.action == ActLoad) begin
            if (!empty_r) res_nxt.status = StBusy;
            else cs_we = 1'b1;
            state_nxt = S_OUT; ovalid_nxt = 1'b1;
          end else if (in_l > in_r) begin
            res_nxt.status = StBadRange;
            state_nxt = S_OUT; ovalid_nxt = 1'b1;
          end else begin
            ql_nxt = in_l; qr_nxt = in_r; fp_nxt = in_l;
            first_nxt = empty_r; state_nxt = S_PLAN;
          end
        end
      end
      S_PLAN: begin
        // Pick the next window move; its code is read in the next state.
        state_nxt = S_CODE; inc_nxt = 1'b1;
        if (first_r) begin
          pos_nxt = fp_r;
        end else if (ql_r < wl_r) begin
          pos_nxt = wl_r - 1'b1; wl_nxt = wl_r - 1'b1;
        end else if (qr_r > wr_r) begin
          pos_nxt = wr_r + 1'b1; wr_nxt = wr_r + 1'b1;
        end else if (ql_r > wl_r) begin
          pos_nxt = wl_r; wl_nxt = wl_r + 1'b1; inc_nxt = 1'b0;
        end else if (qr_r < wr_r) begin
          pos_nxt = wr_r; wr_nxt = wr_r - 1'b1; inc_nxt = 1'b0;
        end else begin
          state_nxt = S_TOP;
        end
      end
      S_CODE: begin
        cs_raddr = pos_r; state_nxt = S_CNT;
      end
      S_CNT: begin
        code_nxt = cs_rdata; cc_raddr = cs_rdata; state_nxt = S_CNTW;
      end
      S_CNTW: begin
        val_nxt = inc_r ? cc_rdata + 1'b1 : cc_rdata - 1'b1;
        cc_we = 1'b1; cc_wdata = val_nxt;
        node_nxt = TreeAw'(CodeSpan) + TreeAw'(code_r);
        mt_we = 1'b1; mt_waddr = node_nxt; mt_wdata = val_nxt;
        state_nxt = S_TRD;
      end
      S_TRD: begin
        mt_raddr = node_r ^ TreeAw'(1); state_nxt = S_TWR;
      end
      S_TWR: begin
        // Parent takes the larger of this node and its sibling.
        node_nxt = node_r >> 1; val_nxt = mx;
        mt_we = 1'b1; mt_waddr = node_nxt; mt_wdata = mx;
        state_nxt = (node_nxt == TreeAw'(1)) ? S_PLAN : S_TRD;
        if (node_nxt == TreeAw'(1) && first_r) begin
          if (fp_r == qr_r) begin
            first_nxt = 1'b0; wl_nxt = ql_r; wr_nxt = qr_r; empty_nxt = 1'b0;
          end else fp_nxt = fp_r + 1'b1;
        end
      end
      S_TOP: begin
        mt_raddr = TreeAw'(1); state_nxt = S_TOPW;
      end
      S_TOPW: begin
        res_nxt.top_count = mt_rdata;
        res_nxt.majority = ({1'b0, mt_rdata} >= {1'b0, len >> 1} + (NodeW+1)'(1));
        res_nxt.status = StOk;
        ovalid_nxt = 1'b1; state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ch.ready) begin
          ovalid_nxt = 1'b0; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; clr_r <= '0; wl_r <= '0; wr_r <= '0;
      empty_r <= 1'b1; first_r <= 1'b0; ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; clr_r <= clr_nxt; wl_r <= wl_nxt; wr_r <= wr_nxt;
      empty_r <= empty_nxt; first_r <= first_nxt; ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ql_r <= ql_nxt; qr_r <= qr_nxt; fp_r <= fp_nxt; inc_r <= inc_nxt;
    pos_r <= pos_nxt; code_r <= code_nxt; node_r <= node_nxt; val_r <= val_nxt;
    res_r <= res_nxt;
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !ovalid_r) else $error("ready while result pending");
  a_window_order: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty_r && state_r == S_IDLE) |-> wl_r <= wr_r) else $error("window inverted");
  a_empty_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(empty_r) |=> !empty_r) else $error("window emptied");
  a_busy_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && !empty_r) |-> !cs_we) else $error("load into busy store");
endmodule
